@@ rtl/core/ssis_pkg.sv @@
// Package for the sorted key set: sizes, field widths, result status codes
// and sequencer state encoding. No dependencies.
package ssis_pkg;

  // Store size and derived widths.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;

  // Operation selector carried on the input tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SRD     = 8'b0000_0010,
    S_SCMP    = 8'b0000_0100,
    S_DECIDE  = 8'b0000_1000,
    S_SHPRIME = 8'b0001_0000,
    S_SHIFT   = 8'b0010_0000,
    S_WRITE   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

endpackage

@@ rtl/core/sorted_set_insert_search_top.sv @@
// Sorted key set top level: key memory, binary search and insert sequencer.
// Depends on ssis_pkg.

// The block keeps up to CAPACITY (64) distinct signed 32-bit keys in
// ascending order in a single-port-write, single-port-read memory. Each input
// beat carries a key on s_axis_tdata and the operation on s_axis_tuser (0
// insert, 1 search); each produces exactly one result beat. A search runs
// the binary search one step at a time, each step a memory read and then a
// compare. An insert then writes the key and, when later entries have to
// move, first primes the shift and then moves each stored entry above the
// position up by one, since the shift streams through the one memory read
// port and one write port. The input is taken only when the sequencer is
// idle; a finished result sits in an output register, so the next key can
// be taken while that result waits.
module sorted_set_insert_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [9:3] position,
                                      // [16:10] count, [17] is_full,
                                      // [18] is_empty, [23:19] zero
);

  localparam int unsigned IdxW = ssis_pkg::IDX_W;
  localparam int unsigned CntW = ssis_pkg::CNT_W;
  localparam int unsigned KeyW = ssis_pkg::KEY_W;
  localparam logic [CntW-1:0] Cap = CntW'(ssis_pkg::CAPACITY);

  ssis_pkg::state_e  state_q, state_d;
  ssis_pkg::status_e status_q, status_d;

  logic                   op_q, op_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [CntW-1:0]        lo_q, lo_d;
  logic [CntW-1:0]        hi_q, hi_d;
  logic                   eq_q, eq_d;
  logic [CntW-1:0]        j_q, j_d;
  logic [CntW-1:0]        key_count_q, key_count_d;
  logic [CntW-1:0]        mid;

  logic signed [KeyW-1:0] mem [ssis_pkg::CAPACITY];
  logic signed [KeyW-1:0] rdata_q;
  logic [IdxW-1:0]        rd_addr;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;
  logic signed [KeyW-1:0] wr_data;

  logic                   out_valid_q, out_valid_d;
  ssis_pkg::status_e      out_status_q, out_status_d;
  logic [CntW-1:0]        out_pos_q, out_pos_d;
  logic [CntW-1:0]        out_count_q, out_count_d;
  logic                   out_full_q, out_full_d;
  logic                   out_empty_q, out_empty_d;

  logic in_beat;
  logic out_free;

  assign s_axis_tready = (state_q == ssis_pkg::S_IDLE);
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);

  // Key memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Sequencer next-state and datapath.
  always_comb begin
    logic [CntW-1:0] jm1;
    logic [CntW-1:0] jm2;
    jm1 = j_q - CntW'(1);
    jm2 = j_q - CntW'(2);

    state_d      = state_q;
    status_d     = status_q;
    op_d         = op_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    eq_d         = eq_q;
    j_d          = j_q;
    key_count_d  = key_count_q;
    rd_addr      = mid[IdxW-1:0];
    wr_en        = 1'b0;
    wr_addr      = j_q[IdxW-1:0];
    wr_data      = rdata_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_full_d   = out_full_q;
    out_empty_d  = out_empty_q;

    case (state_q)
      ssis_pkg::S_IDLE: begin
        if (in_beat) begin
          op_d    = s_axis_tuser;
          key_d   = s_axis_tdata;
          lo_d    = '0;
          hi_d    = key_count_q;
          eq_d    = 1'b0;
          state_d = ssis_pkg::S_SRD;
        end
      end

      // Issue the read of the middle entry, or finish the search.
      ssis_pkg::S_SRD: begin
        if (lo_q == hi_q) begin
          state_d = ssis_pkg::S_DECIDE;
        end else begin
          state_d = ssis_pkg::S_SCMP;
        end
      end

      // Narrow the range; remember equality of the last upper-bound probe.
      ssis_pkg::S_SCMP: begin
        if (rdata_q < key_q) begin
          lo_d = mid + CntW'(1);
        end else begin
          hi_d = mid;
          eq_d = (rdata_q == key_q);
        end
        state_d = ssis_pkg::S_SRD;
      end

      // The final position is lo; the key is present if the last probe matched.
      ssis_pkg::S_DECIDE: begin
        if (op_q == ssis_pkg::OP_SEARCH) begin
          status_d = eq_q ? ssis_pkg::ST_FOUND : ssis_pkg::ST_NOT_FOUND;
          state_d  = ssis_pkg::S_DONE;
        end else if (eq_q) begin
          status_d = ssis_pkg::ST_DUPLICATE;
          state_d  = ssis_pkg::S_DONE;
        end else if (key_count_q >= Cap) begin
          status_d = ssis_pkg::ST_FULL;
          state_d  = ssis_pkg::S_DONE;
        end else if (lo_q == key_count_q) begin
          state_d = ssis_pkg::S_WRITE;
        end else begin
          j_d     = key_count_q;
          state_d = ssis_pkg::S_SHPRIME;
        end
      end

      // Read the last stored entry to start the shift.
      ssis_pkg::S_SHPRIME: begin
        rd_addr = jm1[IdxW-1:0];
        state_d = ssis_pkg::S_SHIFT;
      end

      // Move entry j-1 to j while reading entry j-2.
      ssis_pkg::S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = j_q[IdxW-1:0];
        wr_data = rdata_q;
        rd_addr = jm2[IdxW-1:0];
        j_d     = jm1;
        if (jm1 == lo_q) begin
          state_d = ssis_pkg::S_WRITE;
        end
      end

      // Place the new key at its slot.
      ssis_pkg::S_WRITE: begin
        wr_en       = 1'b1;
        wr_addr     = lo_q[IdxW-1:0];
        wr_data     = key_q;
        key_count_d = key_count_q + CntW'(1);
        status_d    = ssis_pkg::ST_INSERTED;
        state_d     = ssis_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free.
      ssis_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_pos_d    = lo_q;
          out_count_d  = key_count_q;
          out_full_d   = (key_count_q == Cap);
          out_empty_d  = (key_count_q == '0);
          state_d      = ssis_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ssis_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssis_pkg::S_IDLE;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    op_q         <= op_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    eq_q         <= eq_d;
    j_q          <= j_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
    out_full_q   <= out_full_d;
    out_empty_q  <= out_empty_d;
  end

  // Result beat.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_empty_q, out_full_q, out_count_q, out_pos_q,
                          out_status_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= Cap)
    else $error("stored key count exceeds capacity");

  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssis_pkg::S_SHIFT |-> (j_q > lo_q) && (key_count_q < Cap))
    else $error("shift runs at or below the insert position or on a full store");

  a_start_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> state_q == ssis_pkg::S_SRD && lo_q == '0)
    else $error("accepted beat did not start a search");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ssis_pkg::ST_FOUND ||
                    out_status_q == ssis_pkg::ST_DUPLICATE)
    |-> out_pos_q < out_count_q)
    else $error("matched key reported outside the stored range");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssis_pkg::S_WRITE |=> key_count_q == $past(key_count_q) + CntW'(1))
    else $error("insert did not increment the count");
`endif

endmodule

@@ bench/ssis_result_checker.sv @@
// Result checker for the sorted key set: watches both streams, predicts each
// result from its own copy of the key store and compares it field by field.
// Depends on ssis_pkg.
module ssis_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_key_i,     // [31:0] key
  input  logic        in_op_i,      // [0] operation
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,   // [2:0] status, [9:3] position,
                                    // [16:10] count, [17] is_full,
                                    // [18] is_empty, [23:19] zero
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntW = ssis_pkg::CNT_W;
  localparam int unsigned KeyW = ssis_pkg::KEY_W;

  // Expected contents of one result beat.
  typedef struct packed {
    logic              is_empty;
    logic              is_full;
    logic [CntW-1:0]   count;
    logic [CntW-1:0]   position;
    ssis_pkg::status_e status;
  } set_reply_t;

  // One accepted request together with the reply it must produce.
  typedef struct {
    set_reply_t  reply;
    logic [31:0] key;
    logic        op;
  } set_request_t;

  // Shadow copy of the key store; only entries below held_count are valid.
  logic signed [KeyW-1:0] keys_held [ssis_pkg::CAPACITY];
  int unsigned            held_count;
  set_request_t           open_requests [$];
  set_request_t           oldest;
  set_request_t           incoming;

  // Apply one operation to the shadow store and return the reply it gives.
  function automatic set_reply_t model_set_op(input logic op,
                                              input logic signed [KeyW-1:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned j;
    logic        present;
    set_reply_t  r;
    lo = 0;
    hi = held_count;
    // Lower bound: first slot whose key is not less than the new one.
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (keys_held[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    present = (lo < held_count) && (keys_held[lo] == key);
    if (op == ssis_pkg::OP_SEARCH) begin
      r.status = present ? ssis_pkg::ST_FOUND : ssis_pkg::ST_NOT_FOUND;
    end else if (present) begin
      // A duplicate is rejected even when the store is full.
      r.status = ssis_pkg::ST_DUPLICATE;
    end else if (held_count >= ssis_pkg::CAPACITY) begin
      r.status = ssis_pkg::ST_FULL;
    end else begin
      for (j = held_count; j > lo; j--) begin
        keys_held[j] = keys_held[j - 1];
      end
      keys_held[lo] = key;
      held_count++;
      r.status = ssis_pkg::ST_INSERTED;
    end
    r.position = CntW'(lo);
    r.count    = CntW'(held_count);
    r.is_full  = (held_count == ssis_pkg::CAPACITY);
    r.is_empty = (held_count == 0);
    return r;
  endfunction

  // Report one field that differs from its prediction.
  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got, input set_request_t req);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch on %s of key %0d: expected %0d, got %0d", $time,
               field, (req.op == ssis_pkg::OP_SEARCH) ? "search" : "insert",
               $signed(req.key), want, got);
    end
  endfunction

  // Retire result beats against the oldest request, then log new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      open_requests.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (open_requests.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat %h arrived with no request outstanding", $time,
                   out_data_i);
        end else begin
          oldest = open_requests.pop_front();
          check_field("status", oldest.reply.status, out_data_i[2:0], oldest);
          check_field("position", oldest.reply.position, out_data_i[9:3], oldest);
          check_field("count", oldest.reply.count, out_data_i[16:10], oldest);
          check_field("is_full", oldest.reply.is_full, out_data_i[17], oldest);
          check_field("is_empty", oldest.reply.is_empty, out_data_i[18], oldest);
          check_field("padding", '0, out_data_i[23:19], oldest);
        end
      end
      if (in_valid_i && in_ready_i) begin
        incoming.key   = in_key_i;
        incoming.op    = in_op_i;
        incoming.reply = model_set_op(in_op_i, in_key_i);
        open_requests.push_back(incoming);
      end
      pending_o = open_requests.size();
    end
  end

endmodule

@@ bench/sorted_set_insert_search_top_tb.sv @@
// Testbench top for the sorted key set: clock, reset, request and result
// traffic with random gaps, and the final verdict.
// Depends on ssis_pkg, sorted_set_insert_search_top and ssis_result_checker.
module sorted_set_insert_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;

  // Opening requests, operation above key: empty store, extreme keys,
  // duplicates, hits and misses next to stored keys.
  localparam logic [32:0] OPENING_BEATS [17] = '{
    {ssis_pkg::OP_SEARCH, 32'h0000_0000},
    {ssis_pkg::OP_INSERT, 32'h0000_0000},
    {ssis_pkg::OP_INSERT, 32'h7FFF_FFFF},
    {ssis_pkg::OP_INSERT, 32'h8000_0000},
    {ssis_pkg::OP_INSERT, 32'hFFFF_FFFF},
    {ssis_pkg::OP_INSERT, 32'h0000_0001},
    {ssis_pkg::OP_INSERT, 32'h0000_0000},
    {ssis_pkg::OP_INSERT, 32'h8000_0000},
    {ssis_pkg::OP_INSERT, 32'h7FFF_FFFF},
    {ssis_pkg::OP_SEARCH, 32'h8000_0000},
    {ssis_pkg::OP_SEARCH, 32'h7FFF_FFFF},
    {ssis_pkg::OP_SEARCH, 32'h0000_0000},
    {ssis_pkg::OP_SEARCH, 32'h8000_0001},
    {ssis_pkg::OP_SEARCH, 32'h7FFF_FFFE},
    {ssis_pkg::OP_SEARCH, 32'h0000_0002},
    {ssis_pkg::OP_INSERT, 32'h8000_0001},
    {ssis_pkg::OP_INSERT, 32'h7FFF_FFFE}
  };

  localparam logic [31:0] EXTREME_KEYS [6] = '{
    32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] key
  logic        s_axis_tuser;   // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] status, [9:3] position, [16:10] count,
                               // [17] is_full, [18] is_empty, [23:19] zero

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  bit          hold_requested = 1'b0;
  bit          hold_done = 1'b0;
  logic [31:0] offered_keys [$];

  sorted_set_insert_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ssis_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_key_i     (s_axis_tdata),
    .in_op_i      (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Key mix: fully random, keys already offered and their neighbors,
  // extremes, and a narrow band around zero that collides often.
  function automatic logic [31:0] pick_key();
    int unsigned k;
    logic [31:0] base;
    k = $urandom_range(0, 9);
    if (k < 4 || offered_keys.size() == 0) begin
      return $urandom;
    end
    base = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
    if (k < 6) begin
      return base;
    end else if (k == 6) begin
      return $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
    end else if (k == 7) begin
      return EXTREME_KEYS[$urandom_range(0, 5)];
    end
    return 32'($signed($urandom_range(0, 63)) - 32);
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task automatic offer_beat(input logic op, input logic [31:0] key);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    offered_keys.push_back(key);
  endtask

  // Random gap after a beat: mostly none or short, a few long.
  task automatic rest_sender(input bit back_to_back);
    int unsigned k;
    int unsigned gap;
    k = $urandom_range(0, 99);
    if (back_to_back || k < 55) begin
      return;
    end
    gap = (k < 85) ? $urandom_range(1, 3) :
          (k < 97) ? $urandom_range(4, 15) : $urandom_range(30, 100);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Result side: ready runs, single cycles, short stalls, long stalls, and
  // one long hold-off that lets the block back up into its input.
  initial begin : result_sink
    int unsigned k;
    int unsigned n;
    m_axis_tready = 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (hold_requested && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 10) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(20, 120)) @(posedge clk_i);
        end else if (k < 70) begin
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end else begin
          n = (k < 93) ? $urandom_range(1, 4) : $urandom_range(20, 80);
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  // Request side: reset, opening beats, then the random mix.
  initial begin : request_source
    logic op;
    bit   back_to_back;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ssis_pkg::OP_INSERT;
    back_to_back  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 17; i++) begin
      offer_beat(OPENING_BEATS[i][32], OPENING_BEATS[i][31:0]);
      rest_sender(1'b0);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Every hundred beats choose between gapped and back-to-back traffic.
      if (i % 100 == 0) begin
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      if (i == 400) begin
        hold_requested = 1'b1;
      end
      // At random beat 800 of 1300, let every outstanding result drain first.
      if (i == 800) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      op = ($urandom_range(0, 99) < 35) ? ssis_pkg::OP_INSERT : ssis_pkg::OP_SEARCH;
      offer_beat(op, pick_key());
      rest_sender(back_to_back);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
